/* rtl/glu_pkg.sv */
`timescale 1ns / 1ps

package glu_pkg;

    // command codes carried on s_tuser
    localparam logic CMD_GCD = 1'b0;
    localparam logic CMD_LCM = 1'b1;

    // top level to core
    typedef struct packed {
        logic start;
        logic cmd;
        logic res_ready;
    } glu_ctl_t;

    // core to top level
    typedef struct packed {
        logic idle;
        logic res_valid;
        logic ovf;
    } glu_stat_t;

endpackage

/* rtl/gcd_lcm_unit.sv */
`timescale 1ns / 1ps

// Integer gcd / lcm of the magnitudes of two signed DATA_WIDTH-bit operands, one result
// beat per input beat. The adds and subtracts run through one shared adder under a small
// sequencer, so the block takes one item at a time: sign handling of each operand in turn,
// a binary gcd reduction by shifts, swaps and subtracts, one shift back per common factor
// of two, and for lcm a restoring division plus a shift-add multiply. The result sits in
// an output register, so the next item is taken while it waits. An lcm with a zero
// operand gives 0; a value above 2^(DATA_WIDTH-1)-1 saturates there and sets overflow.
module gcd_lcm_unit import glu_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    localparam int IN_TW  = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW = ((DATA_WIDTH - 1 + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_TW-1:0]  s_tdata,   // value_a, value_b, zero pad
    input  logic [0:0]        s_tuser,   // command
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_TW-1:0] m_tdata,   // result, zero pad
    output logic [0:0]        m_tuser    // overflow
);

    localparam logic [DATA_WIDTH-2:0] MAXV = '1;

    glu_ctl_t              ctl;
    glu_stat_t             stat;
    logic [DATA_WIDTH-2:0] core_res;
    logic                  out_free;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [DATA_WIDTH-2:0] res_out_reg, res_out_next;
    logic                  ovf_out_reg, ovf_out_next;

    assign s_tready      = stat.idle;
    assign out_free      = !m_tvalid_reg || m_tready;
    assign ctl.start     = s_tvalid && stat.idle;
    assign ctl.cmd       = s_tuser[0];
    assign ctl.res_ready = out_free;

    glu_core #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctl    (ctl),
        .op_a   (s_tdata[DATA_WIDTH-1:0]),
        .op_b   (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .stat   (stat),
        .res    (core_res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        res_out_next  = res_out_reg;
        ovf_out_next  = ovf_out_reg;
        if (out_free) begin
            m_tvalid_next = stat.res_valid;
            if (stat.res_valid) begin
                res_out_next = core_res;
                ovf_out_next = stat.ovf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        res_out_reg <= res_out_next;
        ovf_out_reg <= ovf_out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TW'(res_out_reg);
    assign m_tuser  = ovf_out_reg;

    // an accepted beat keeps the input closed for the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    // a saturated result carries the maximum value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[DATA_WIDTH-2:0] == MAXV)
        else $error("overflow flagged without saturated result");

    // a finished result in the core means the input stays closed
    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.res_valid |-> !s_tready)
        else $error("input open while core holds a result");

endmodule

/* rtl/glu_core.sv */
`timescale 1ns / 1ps

module glu_core import glu_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  glu_ctl_t              ctl,
    input  logic [DATA_WIDTH-1:0] op_a,
    input  logic [DATA_WIDTH-1:0] op_b,
    output glu_stat_t             stat,
    output logic [DATA_WIDTH-2:0] res
);

    localparam int DW = DATA_WIDTH;
    localparam int AW = DW + 2;
    localparam int KW = $clog2(DW);
    localparam int CW = $clog2(DW + 1);
    localparam logic [DW-2:0] MAXV = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NEG_A,
        S_NEG_B,
        S_REDUCE,
        S_SHIFT,
        S_DIV,
        S_MUL,
        S_LCM_OUT,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic            cmd_reg, cmd_next;
    logic [DW-1:0]   x_reg, x_next;
    logic [DW-1:0]   y_reg, y_next;
    logic [DW-1:0]   ma_reg, ma_next;
    logic [DW-1:0]   mb_reg, mb_next;
    logic [DW-1:0]   g_reg, g_next;
    logic [DW-1:0]   q_reg, q_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW:0]     acc_reg, acc_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic [DW-2:0]   res_reg, res_next;

    // shared adder / subtractor
    logic [AW-1:0]   add_x, add_y, sum;
    logic            add_sub;
    logic [DW:0]     div_win;

    assign div_win = {rem_reg, q_reg[DW-1]};

    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (state_reg)
            S_NEG_A: begin
                add_y   = {2'b00, x_reg};
                add_sub = 1'b1;
            end
            S_NEG_B: begin
                add_y   = {2'b00, y_reg};
                add_sub = 1'b1;
            end
            S_REDUCE: begin
                add_x   = {2'b00, x_reg};
                add_y   = {2'b00, y_reg};
                add_sub = 1'b1;
            end
            S_DIV: begin
                add_x   = {1'b0, div_win};
                add_y   = {2'b00, g_reg};
                add_sub = 1'b1;
            end
            S_MUL: begin
                add_x = {acc_reg, 1'b0};
                add_y = q_reg[DW-1] ? {2'b00, mb_reg} : '0;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
        sum = add_x + (add_sub ? ~add_y : add_y) + AW'(add_sub);
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        g_next     = g_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE: begin
                if (ctl.start) begin
                    cmd_next   = ctl.cmd;
                    x_next     = op_a;
                    y_next     = op_b;
                    state_next = S_NEG_A;
                end
            end
            S_NEG_A: begin
                if (x_reg[DW-1]) begin
                    x_next = sum[DW-1:0];
                end
                state_next = S_NEG_B;
            end
            S_NEG_B: begin
                if (y_reg[DW-1]) begin
                    y_next = sum[DW-1:0];
                end
                ma_next    = x_reg;
                mb_next    = y_next;
                k_next     = '0;
                state_next = S_REDUCE;
            end
            S_REDUCE: begin
                if (x_reg == '0) begin
                    g_next     = y_reg;
                    state_next = S_SHIFT;
                end else if (y_reg == '0) begin
                    g_next     = x_reg;
                    state_next = S_SHIFT;
                end else if (!x_reg[0] && !y_reg[0]) begin
                    // strip a common factor of two
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + 1'b1;
                end else if (!x_reg[0]) begin
                    x_next = x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_next = y_reg >> 1;
                end else if (sum[AW-1]) begin
                    // keep the larger odd value in x
                    x_next = y_reg;
                    y_next = x_reg;
                end else begin
                    x_next = sum[DW-1:0];
                end
            end
            S_SHIFT: begin
                if (k_reg != '0) begin
                    g_next = g_reg << 1;
                    k_next = k_reg - 1'b1;
                end else if (cmd_reg == CMD_GCD) begin
                    res_next   = g_reg[DW-1] ? MAXV : g_reg[DW-2:0];
                    ovf_next   = g_reg[DW-1];
                    state_next = S_DONE;
                end else if (ma_reg == '0 || mb_reg == '0) begin
                    res_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_DONE;
                end else begin
                    q_next     = ma_reg;
                    rem_next   = '0;
                    cnt_next   = CW'(DW);
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (!sum[AW-1]) begin
                    rem_next = sum[DW-1:0];
                    q_next   = {q_reg[DW-2:0], 1'b1};
                end else begin
                    rem_next = div_win[DW-1:0];
                    q_next   = {q_reg[DW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    cnt_next   = CW'(DW);
                    acc_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                // quotient MSB first; hold the accumulator once it passes the max
                if (!ovf_reg) begin
                    acc_next = sum[DW:0];
                    if (sum[DW] || sum[DW-1]) begin
                        ovf_next = 1'b1;
                    end
                end
                q_next   = q_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    state_next = S_LCM_OUT;
                end
            end
            S_LCM_OUT: begin
                res_next   = ovf_reg ? MAXV : acc_reg[DW-2:0];
                state_next = S_DONE;
            end
            S_DONE: begin
                if (ctl.res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cmd_reg <= cmd_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        g_reg   <= g_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        k_reg   <= k_next;
        cnt_reg <= cnt_next;
        ovf_reg <= ovf_next;
        res_reg <= res_next;
    end

    assign stat.idle      = (state_reg == S_IDLE);
    assign stat.res_valid = (state_reg == S_DONE);
    assign stat.ovf       = ovf_reg;
    assign res            = res_reg;

endmodule
